>>> rtl/core/bida_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bida_pkg: shared types for the bitmap identifier allocator
// request and result codes, controller states and the command and status
// bundles between controller and datapath
// ----------------------------------------------------------------------------
package bida_pkg;

    // request kind, carried on s_tuser
    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    // result status, carried on m_tuser
    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_BAD  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_MODIFY
    } state_t;

    localparam int SLOT_W    = 12;
    localparam int GRANT_W   = 11;
    localparam int BIT_IDX_W = 6;
    localparam int MAP_W     = 64;

    // controller to datapath
    typedef struct packed {
        logic clear;      // write a zero row at the clear counter
        logic accept;     // latch the incoming request
        logic lookup;     // pick the row and read it
        logic emit_full;  // load a full result
        logic emit_bad;   // load an out-of-range result
        logic commit;     // write back row and summary, load an ok result
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic any_free;
        logic slot_bad;
        logic op_release;
        logic out_free;
    } dp_stat_t;

endpackage

>>> rtl/core/bida_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bida_ctrl: allocator sequencer
// runs the clearing pass after reset, then walks each request through
// lookup and modify, holding when the result register is occupied
// ----------------------------------------------------------------------------
module bida_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  bida_pkg::dp_stat_t stat,
    output bida_pkg::dp_cmd_t  cmd
);
    import bida_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_valid) begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (stat.op_release ? stat.slot_bad : !stat.any_free) begin
                    if (stat.out_free) begin
                        state_next = S_IDLE;
                    end
                end else begin
                    state_next = S_MODIFY;
                end
            end
            S_MODIFY: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
            end
            S_IDLE: begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            S_LOOKUP: begin
                if (stat.op_release) begin
                    if (stat.slot_bad) begin
                        cmd.emit_bad = stat.out_free;
                    end else begin
                        cmd.lookup = 1'b1;
                    end
                end else begin
                    if (!stat.any_free) begin
                        cmd.emit_full = stat.out_free;
                    end else begin
                        cmd.lookup = 1'b1;
                    end
                end
            end
            S_MODIFY: begin
                cmd.commit = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/core/bida_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bida_dp: allocator datapath
// used-bit memory of 64-bit rows, per-row full summary, the two priority
// encoders and the result register
// ----------------------------------------------------------------------------
module bida_dp #(
    parameter int ID_COUNT = 2048
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  bida_pkg::dp_cmd_t                   cmd,
    output bida_pkg::dp_stat_t                  stat,
    input  logic                                in_op,
    input  logic [bida_pkg::SLOT_W-1:0]         in_slot_id,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [bida_pkg::GRANT_W-1:0]        out_granted_id,
    output logic [1:0]                          out_status
);
    import bida_pkg::*;

    localparam int ID_WORDS   = (ID_COUNT + MAP_W - 1) / MAP_W;
    localparam int WORD_AW    = (ID_WORDS > 1) ? $clog2(ID_WORDS) : 1;
    localparam int LAST_VALID = ID_COUNT - (ID_WORDS - 1) * MAP_W;
    localparam logic [MAP_W-1:0] PAD_LAST =
        (LAST_VALID >= MAP_W) ? '0 : ~((MAP_W'(1) << LAST_VALID) - MAP_W'(1));
    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(ID_WORDS - 1);

    logic [MAP_W-1:0]    used_mem [ID_WORDS];
    logic [ID_WORDS-1:0] summary_reg;
    logic [WORD_AW-1:0]  clr_cnt_reg;
    logic                op_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [WORD_AW-1:0]  word_idx_reg;
    logic [MAP_W-1:0]    rd_word_reg;
    logic                out_valid_reg;
    logic [GRANT_W-1:0]  granted_reg;
    logic [1:0]          status_reg;

    logic                free_found;
    logic [WORD_AW-1:0]  free_word;
    logic [WORD_AW-1:0]  slot_word;
    logic [WORD_AW-1:0]  rd_addr;
    logic [MAP_W-1:0]    pad;
    logic [MAP_W-1:0]    seen_word;
    logic [BIT_IDX_W-1:0] free_bit;
    logic [BIT_IDX_W-1:0] mod_bit;
    logic [MAP_W-1:0]    new_word;
    logic                row_full;
    logic                slot_bad;
    logic                out_free;
    logic                mem_we;
    logic [WORD_AW-1:0]  wr_addr;
    logic [MAP_W-1:0]    wr_data;

    // lowest row whose summary bit says it still has room
    always_comb begin
        free_found = 1'b0;
        free_word  = '0;
        for (int w = ID_WORDS - 1; w >= 0; w--) begin
            if (!summary_reg[w]) begin
                free_found = 1'b1;
                free_word  = WORD_AW'(w);
            end
        end
    end

    assign slot_bad  = 32'(slot_reg) >= 32'(ID_COUNT);
    assign slot_word = WORD_AW'(slot_reg >> BIT_IDX_W);
    assign rd_addr   = (op_reg == OP_RELEASE) ? slot_word : free_word;

    // padding bits past the last identifier count as used
    assign pad       = (word_idx_reg == LAST_WORD) ? PAD_LAST : '0;
    assign seen_word = rd_word_reg | pad;

    // lowest clear bit of the row
    always_comb begin
        free_bit = '0;
        for (int b = MAP_W - 1; b >= 0; b--) begin
            if (!seen_word[b]) begin
                free_bit = BIT_IDX_W'(b);
            end
        end
    end

    assign mod_bit  = (op_reg == OP_RELEASE) ? slot_reg[BIT_IDX_W-1:0] : free_bit;
    assign new_word = (op_reg == OP_RELEASE) ?
                      (rd_word_reg & ~(MAP_W'(1) << mod_bit)) :
                      (rd_word_reg |  (MAP_W'(1) << mod_bit));
    assign row_full = &(new_word | pad);

    assign out_free = !out_valid_reg || out_ready;
    assign mem_we   = cmd.clear || cmd.commit;
    assign wr_addr  = cmd.clear ? clr_cnt_reg : word_idx_reg;
    assign wr_data  = cmd.clear ? '0 : new_word;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            used_mem[wr_addr] <= wr_data;
        end
        if (cmd.lookup) begin
            rd_word_reg <= used_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            summary_reg <= '0;
            clr_cnt_reg <= '0;
        end else begin
            if (cmd.clear) begin
                clr_cnt_reg <= clr_cnt_reg + WORD_AW'(1);
            end
            if (cmd.commit) begin
                summary_reg[word_idx_reg] <= row_full;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg   <= in_op;
            slot_reg <= in_slot_id;
        end
        if (cmd.lookup) begin
            word_idx_reg <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit || cmd.emit_full || cmd.emit_bad) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            granted_reg <= (op_reg == OP_RELEASE) ? '0 :
                           GRANT_W'({word_idx_reg, free_bit});
            status_reg  <= STAT_OK;
        end else if (cmd.emit_full) begin
            granted_reg <= '0;
            status_reg  <= STAT_FULL;
        end else if (cmd.emit_bad) begin
            granted_reg <= '0;
            status_reg  <= STAT_BAD;
        end
    end

    assign stat.clr_last   = clr_cnt_reg == LAST_WORD;
    assign stat.any_free   = free_found;
    assign stat.slot_bad   = slot_bad;
    assign stat.op_release = op_reg == OP_RELEASE;
    assign stat.out_free   = out_free;

    assign out_valid      = out_valid_reg;
    assign out_granted_id = granted_reg;
    assign out_status     = status_reg;

endmodule

>>> rtl/core/bitmap_id_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_id_allocator: lowest-free identifier allocator
// one used bit per identifier, searched through a per-row full summary
// ----------------------------------------------------------------------------
// usage
//   s_ channel takes one request word: s_tuser is the kind (allocate or
//   release), s_tdata[11:0] is the identifier to release (ignored on
//   allocate)
//   m_ channel returns one result word per request: m_tdata[10:0] is the
//   granted identifier (zero unless an allocate succeeded), m_tuser is the
//   status (ok, no free identifier, released identifier out of range)
//   a request touching the bitmap runs accept, summary encode and row
//   read, then row encode and write-back; a full or out-of-range
//   rejection loads its result at the lookup step; the single-port row
//   memory and the read-modify-write of one row bound the rate at one
//   request in flight, so s_tready is high only in the idle state
//   the result sits in an output register; the next request is taken
//   while it waits, and only the final step holds if m_tready stays low
//   after reset the block clears the row memory one row a cycle, all
//   ceil(ID_COUNT / 64) rows, with s_tready low
// ----------------------------------------------------------------------------
module bitmap_id_allocator #(
    parameter int ID_COUNT = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] slot_id, [15:12] zero
    input  logic [0:0]  s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [10:0] granted_id, [15:11] zero
    output logic [1:0]  m_tuser    // [1:0] status
);
    import bida_pkg::*;

    dp_cmd_t             cmd;
    dp_stat_t            stat;
    logic [GRANT_W-1:0]  granted_id;

    // sequencer: clearing pass, then accept, lookup and modify
    bida_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // bitmap memory, summary bits, encoders and result register
    bida_dp #(
        .ID_COUNT (ID_COUNT)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .in_op          (s_tuser[0]),
        .in_slot_id     (s_tdata[SLOT_W-1:0]),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .out_granted_id (granted_id),
        .out_status     (m_tuser)
    );

    // pad the grant up to a whole number of bytes
    assign m_tdata = 16'(granted_id);

endmodule

>>> rtl/core/bida_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bida_checker: port-level checks for the allocator
// watches both channels of the top level and is bound to it below
// ----------------------------------------------------------------------------
module bida_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import bida_pkg::*;

    // no result is presented right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // rejected requests never carry a grant
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STAT_FULL || m_tuser == STAT_BAD) |-> m_tdata == 16'd0)
        else $error("rejected result carries a grant");

    // one request in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted back to back");

endmodule

bind bitmap_id_allocator bida_checker u_bida_checker (.*);

>>> bench/tb_bitmap_id_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_id_allocator: self-checking bench for the bitmap id allocator
// requests go in on the s_ stream and results come back on the m_ stream.
// each accepted request runs through a bit-level copy of the allocation
// table, and each result word is compared field by field against it.
// both sides throttle at random, apart from one calm stretch
// ----------------------------------------------------------------------------
module tb_bitmap_id_allocator;
    import bida_pkg::*;

    localparam int ID_COUNT   = 2048;
    localparam int HALF_CLK   = 4;
    localparam int STALL_MAX  = 4000;   // cycles with no word moving on either side
    localparam int PHASE_LEN  = 130;
    localparam int NUM_PHASES = 5;

    // expected result word
    typedef struct {
        logic [GRANT_W-1:0] granted_id;
        status_t            status;
    } grant_result_t;

    // ------------------------------------------------------------------------
    // id table tracker: mirrors the used bits and keeps the results owed
    // ------------------------------------------------------------------------
    class id_table_tracker;
        bit [ID_COUNT-1:0] taken;
        grant_result_t     owed[$];
        int                errors;
        int                n_grant, n_full, n_bad, n_release;

        function new();
            taken     = '0;
            errors    = 0;
            n_grant   = 0;
            n_full    = 0;
            n_bad     = 0;
            n_release = 0;
        endfunction

        // work out the result of one accepted request and update the table
        function void note_request(op_t op, logic [SLOT_W-1:0] slot);
            grant_result_t r;
            bit            found;
            found        = 1'b0;
            r.granted_id = '0;
            r.status     = STAT_OK;
            if (op == OP_ALLOC) begin
                // lowest free id wins
                for (int i = 0; i < ID_COUNT; i++) begin
                    if (!found && !taken[i]) begin
                        found        = 1'b1;
                        taken[i]     = 1'b1;
                        r.granted_id = GRANT_W'(i);
                    end
                end
                if (!found) begin
                    r.status = STAT_FULL;
                    n_full++;
                end else begin
                    n_grant++;
                end
            end else if (slot >= ID_COUNT) begin
                r.status = STAT_BAD;
                n_bad++;
            end else begin
                // releasing an id that is already free is fine
                taken[slot] = 1'b0;
                n_release++;
            end
            owed.push_back(r);
        endfunction

        function void check_result(logic [15:0] data, logic [1:0] user);
            grant_result_t e;
            if (owed.size() == 0) begin
                $error("result word with nothing outstanding: tdata %h tuser %h", data, user);
                errors++;
            end else begin
                e = owed.pop_front();
                if (data[GRANT_W-1:0] !== e.granted_id) begin
                    $error("granted_id: expected %0d, got %0d", e.granted_id,
                           data[GRANT_W-1:0]);
                    errors++;
                end
                if (data[15:GRANT_W] !== '0) begin
                    $error("tdata padding: expected 0, got %h", data[15:GRANT_W]);
                    errors++;
                end
                if (user !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, user);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and dut
    // ------------------------------------------------------------------------
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // [11:0] slot_id, [15:12] zero
    logic [0:0]  s_tuser  = '0;    // [0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // [10:0] granted_id, [15:11] zero
    logic [1:0]  m_tuser;          // [1:0] status

    bit              throttle = 1'b1;   // random idling on both sides
    int              quiet_cycles = 0;
    id_table_tracker tracker = new();

    always #HALF_CLK aclk = ~aclk;

    bitmap_id_allocator #(.ID_COUNT(ID_COUNT)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // receiver backpressure: about a quarter of cycles stalled while throttling
    always @(posedge aclk) begin
        m_tready <= !throttle || ($urandom_range(99) >= 25);
    end

    // monitor: values read here are the ones sampled at this edge, since every
    // driver updates through nonblocking assignments
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                tracker.note_request(op_t'(s_tuser[0]), s_tdata[SLOT_W-1:0]);
            if (m_tvalid && m_tready)
                tracker.check_result(m_tdata, m_tuser);
            // watchdog on words moving in either direction
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_MAX) begin
                $display("timeout: no word moved for %0d cycles", STALL_MAX);
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------------
    // one request word; random idle cycles ahead of it while throttling
    task automatic push_request(input op_t op, input logic [SLOT_W-1:0] slot);
        while (throttle && $urandom_range(99) < 25) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'd0, slot};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic alloc_id();
        push_request(OP_ALLOC, '0);
    endtask

    task automatic release_id(input logic [SLOT_W-1:0] slot);
        push_request(OP_RELEASE, slot);
    endtask

    // release target mix: mostly valid ids, some anywhere in the field,
    // some strictly out of range
    function automatic logic [SLOT_W-1:0] pick_slot();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return SLOT_W'($urandom_range(4095, ID_COUNT));
        else if (roll < 25)
            return SLOT_W'($urandom_range(4095));
        else if (roll < 45)
            return SLOT_W'($urandom_range(127));   // crowd the low rows
        else
            return SLOT_W'($urandom_range(ID_COUNT - 1));
    endfunction

    // at least one edge passes so the last accepted request is counted
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tracker.pending() != 0);
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    int alloc_pct [NUM_PHASES] = '{50, 25, 75, 50, 40};

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // opening checks on a fresh table
        repeat (4) alloc_id();           // grants 0..3
        release_id(12'd0);
        release_id(12'd0);               // already free, silent ok
        alloc_id();                      // lowest again: 0
        release_id(12'd2047);            // top id, free
        release_id(12'd2048);            // first out-of-range value
        release_id(12'd4095);            // largest slot value
        release_id(12'hAAA);
        release_id(12'h555);
        release_id(12'd2);
        release_id(12'd1);
        alloc_id();
        alloc_id();
        alloc_id();

        // fill row zero and spill into row one, then reopen both sides
        // of the row boundary
        repeat (70) alloc_id();
        release_id(12'd63);
        release_id(12'd64);
        alloc_id();                      // 63 from the reopened row zero
        alloc_id();                      // 64
        wait_drained();

        // random mix in phases of differing allocate bias
        for (int p = 0; p < NUM_PHASES; p++) begin
            throttle = (p != 1);         // phase one runs without any idling
            for (int i = 0; i < PHASE_LEN; i++) begin
                if ($urandom_range(99) < alloc_pct[p])
                    alloc_id();
                else
                    release_id(pick_slot());
            end
            if (p == 2)
                wait_drained();          // sender holds off until all results are in
        end
        throttle = 1'b1;

        wait_drained();
        repeat (16) @(posedge aclk);

        $display("covered %0d grants, %0d full replies, %0d releases, %0d out-of-range",
                 tracker.n_grant, tracker.n_full, tracker.n_release, tracker.n_bad);
        $display("row boundary refill and random allocate/release mix under throttling");
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
